@@ rtl/core/pbhs_pkg.sv @@
// Package for the page buffer history store.
// Holds sizes, codes and the control and status structs shared by all modules.
// No dependencies.
`default_nettype none
package pbhs_pkg;

  localparam int PAGE_ELEMENTS = 128;
  localparam int BUFFER_SLOTS  = 4;
  localparam int HISTORY_DEPTH = 4;
  localparam int MAX_PAGES     = 64;
  localparam int TOTAL_ELEMS   = MAX_PAGES * PAGE_ELEMENTS;

  localparam int IDX_W   = 14;
  localparam int DATA_W  = 32;
  localparam int EADDR_W = $clog2(TOTAL_ELEMS);
  localparam int PAGE_W  = 6;
  localparam int SLOT_W  = 2;
  localparam int POS_W   = 2;
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int OFS_W   = $clog2(PAGE_ELEMENTS);
  localparam int HADDR_W = EADDR_W + POS_W;
  localparam int CLR_W   = EADDR_W + 1;
  localparam int PADDR_W = 3;

  localparam int RESET_PAGES_RAW = (8192 + PAGE_ELEMENTS - 1) / PAGE_ELEMENTS;
  localparam int RESET_PAGES = RESET_PAGES_RAW > MAX_PAGES ? MAX_PAGES : RESET_PAGES_RAW;
  localparam logic [IDX_W-1:0] RESET_SIZE = IDX_W'(8192);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam logic [PADDR_W-1:0] ADDR_ARRAY_SIZE = PADDR_W'(0);

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] head;
  } meta_t;

  typedef struct packed {
    logic clr;
    logic latch;
    logic lookup;
    logic meta_wr;
    logic rd_latest;
    logic rd_first;
    logic next_entry;
    logic emit_err;
    logic emit_plain;
    logic emit_entry;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_range;
    logic is_write;
    logic cnt_zero;
    logic entry_last;
    logic out_taken;
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/core/pbhs_ctrl.sv @@
// Controller state machine of the page buffer history store.
// Depends on pbhs_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none
module pbhs_ctrl
  import pbhs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t st,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_META, S_LAT, S_ENT, S_WAIT_END, S_WAIT_ENT
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (st.clr_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.clr = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (st.out_range) begin
          cmd.emit_err = 1'b1;
          state_next = S_WAIT_END;
        end else begin
          cmd.lookup = 1'b1;
          state_next = S_META;
        end
      end
      S_META: begin
        if (st.is_write) begin
          cmd.meta_wr = 1'b1;
          cmd.emit_plain = 1'b1;
          state_next = S_WAIT_END;
        end else if (st.cnt_zero) begin
          cmd.emit_plain = 1'b1;
          state_next = S_WAIT_END;
        end else begin
          cmd.rd_latest = 1'b1;
          state_next = S_LAT;
        end
      end
      S_LAT: begin
        cmd.rd_first = 1'b1;
        state_next = S_ENT;
      end
      S_ENT: begin
        cmd.emit_entry = 1'b1;
        state_next = S_WAIT_ENT;
      end
      S_WAIT_END: begin
        if (st.out_taken) begin
          state_next = S_IDLE;
        end
      end
      S_WAIT_ENT: begin
        if (st.out_taken) begin
          if (st.entry_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_entry = 1'b1;
            state_next = S_ENT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall) else $error("item taken during clearing pass");
  a_meta_follows_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == S_META) |-> $past(state == S_LOOKUP)) else $error("meta stage out of order");
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_err, cmd.emit_plain, cmd.emit_entry})) else $error("double emit");
`endif

endmodule
`default_nettype wire

@@ rtl/core/pbhs_dp.sv @@
// Datapath of the page buffer history store: slot buffer, element metadata,
// history memory and the output register. Depends on pbhs_pkg.
`default_nettype none
module pbhs_dp
  import pbhs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ctrl_cmd_t                cmd,
  output dp_status_t                    st,
  input  wire logic [IDX_W-1:0]         array_size,
  input  wire logic                     command,
  input  wire logic [IDX_W-1:0]         index,
  input  wire logic signed [DATA_W-1:0] write_value,
  input  wire logic [DATA_W-1:0]        now,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          status,
  output logic                          hit,
  output logic [SLOT_W-1:0]             slot,
  output logic                          wrote_back,
  output logic [PAGE_W-1:0]             victim_page,
  output logic signed [DATA_W-1:0]      latest_value,
  output logic                          modified_flag,
  output logic signed [DATA_W-1:0]      history_entry,
  output logic [POS_W-1:0]              history_pos,
  output logic                          last
);

  logic              cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] wv_r;
  logic [DATA_W-1:0] now_r;

  logic [PAGE_W-1:0] slot_page  [BUFFER_SLOTS];
  logic              slot_valid [BUFFER_SLOTS];
  logic              slot_dirty [BUFFER_SLOTS];
  logic [DATA_W-1:0] slot_time  [BUFFER_SLOTS];

  logic              hit_r;
  logic [SLOT_W-1:0] slot_r;
  logic              wb_r;
  logic [PAGE_W-1:0] victim_r;

  meta_t             meta_mem [TOTAL_ELEMS];
  meta_t             meta_rd;
  logic [DATA_W-1:0] hist_mem [TOTAL_ELEMS * HISTORY_DEPTH];
  logic [DATA_W-1:0] hist_rd;
  logic [DATA_W-1:0] latest_r;
  logic [POS_W-1:0]  j;
  logic [CLR_W-1:0]  clr_cnt;

  logic [PAGE_W-1:0]  page;
  logic [EADDR_W-1:0] eaddr;
  logic               found;
  logic [SLOT_W-1:0]  hit_s;
  logic               has_empty;
  logic [SLOT_W-1:0]  empty_s;
  logic [SLOT_W-1:0]  old_s;
  logic [SLOT_W-1:0]  sel_s;
  logic               full_hist;
  logic [POS_W-1:0]   wpos;
  logic [POS_W-1:0]   rpos;
  logic               emit_any;
  logic               out_taken;

  assign page  = PAGE_W'(idx_r[IDX_W-1:OFS_W]);
  assign eaddr = idx_r[EADDR_W-1:0];
  assign emit_any  = cmd.emit_err | cmd.emit_plain | cmd.emit_entry;
  assign out_taken = out_valid & ~out_stall;

  always_comb begin
    found = 1'b0;
    hit_s = '0;
    has_empty = 1'b0;
    empty_s = '0;
    old_s = '0;
    for (int i = BUFFER_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_page[i] == page) begin
        found = 1'b1;
        hit_s = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        has_empty = 1'b1;
        empty_s = SLOT_W'(i);
      end
    end
    for (int i = 1; i < BUFFER_SLOTS; i++) begin
      if (slot_time[i] < slot_time[old_s]) begin
        old_s = SLOT_W'(i);
      end
    end
    priority if (found) begin
      sel_s = hit_s;
    end else if (has_empty) begin
      sel_s = empty_s;
    end else begin
      sel_s = old_s;
    end
  end

  assign full_hist = (meta_rd.cnt >= CNT_W'(HISTORY_DEPTH));
  assign wpos = full_hist ? meta_rd.head : POS_W'(meta_rd.head + POS_W'(meta_rd.cnt));

  always_comb begin
    priority if (cmd.rd_latest) begin
      rpos = POS_W'(meta_rd.head + POS_W'(meta_rd.cnt) - POS_W'(1));
    end else if (cmd.rd_first) begin
      rpos = meta_rd.head;
    end else begin
      rpos = POS_W'(meta_rd.head + j + POS_W'(1));
    end
  end

  assign st.clr_done   = clr_cnt[CLR_W-1];
  assign st.out_range  = (idx_r >= array_size) || (idx_r >= IDX_W'(TOTAL_ELEMS));
  assign st.is_write   = (cmd_r == CMD_WRITE);
  assign st.cnt_zero   = (meta_rd.cnt == '0);
  assign st.entry_last = (j == POS_W'(meta_rd.cnt - CNT_W'(1)));
  assign st.out_taken  = out_taken;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= command;
      idx_r <= index;
      wv_r  <= write_value;
      now_r <= now;
    end
    if (cmd.lookup) begin
      hit_r    <= found;
      slot_r   <= sel_s;
      wb_r     <= ~found & ~has_empty & slot_dirty[old_s];
      victim_r <= (~found & ~has_empty & slot_dirty[old_s]) ? slot_page[old_s] : '0;
      meta_rd  <= meta_mem[eaddr];
    end
    if (cmd.clr) begin
      meta_mem[clr_cnt[EADDR_W-1:0]] <= '0;
    end else if (cmd.meta_wr) begin
      meta_mem[eaddr] <= full_hist ? meta_t'{meta_rd.cnt, POS_W'(meta_rd.head + POS_W'(1))}
                                   : meta_t'{CNT_W'(meta_rd.cnt + CNT_W'(1)), meta_rd.head};
    end
    if (cmd.meta_wr) begin
      hist_mem[{eaddr, wpos}] <= wv_r;
    end
    if (cmd.rd_latest || cmd.rd_first || cmd.next_entry) begin
      hist_rd <= hist_mem[{eaddr, rpos}];
    end
    if (cmd.rd_first) begin
      latest_r <= hist_rd;
    end
    if (cmd.rd_first) begin
      j <= '0;
    end else if (cmd.next_entry) begin
      j <= POS_W'(j + POS_W'(1));
    end
    if (emit_any) begin
      status        <= cmd.emit_err;
      hit           <= cmd.emit_err ? 1'b0 : hit_r;
      slot          <= cmd.emit_err ? '0 : slot_r;
      wrote_back    <= cmd.emit_err ? 1'b0 : wb_r;
      victim_page   <= cmd.emit_err ? '0 : victim_r;
      latest_value  <= cmd.emit_entry ? latest_r : '0;
      modified_flag <= cmd.emit_entry;
      history_entry <= cmd.emit_entry ? hist_rd : '0;
      history_pos   <= cmd.emit_entry ? j : '0;
      last          <= cmd.emit_entry ? st.entry_last : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < BUFFER_SLOTS; i++) begin
        slot_page[i]  <= PAGE_W'(i);
        slot_valid[i] <= (i < RESET_PAGES);
        slot_dirty[i] <= 1'b0;
        slot_time[i]  <= '0;
      end
    end else begin
      if (cmd.clr) begin
        clr_cnt <= CLR_W'(clr_cnt + CLR_W'(1));
      end
      if (emit_any) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
      if (cmd.lookup) begin
        if (!found) begin
          slot_page[sel_s]  <= page;
          slot_valid[sel_s] <= 1'b1;
          slot_dirty[sel_s] <= (cmd_r == CMD_WRITE);
          slot_time[sel_s]  <= now_r;
        end else if (cmd_r == CMD_WRITE) begin
          slot_dirty[sel_s] <= 1'b1;
          slot_time[sel_s]  <= now_r;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_err || cmd.emit_plain || cmd.emit_entry) |-> !out_valid)
    else $error("result overwrites a pending one");
  a_slot_holds_page: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |=> (slot_valid[slot_r] && slot_page[slot_r] == page))
    else $error("selected slot does not hold the page");
  a_entry_has_history: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_entry |-> (meta_rd.cnt != '0))
    else $error("entry emitted for empty history");
`endif

endmodule
`default_nettype wire

@@ rtl/core/page_buffer_history_store_top.sv @@
// Page buffer history store, top level: configuration port, controller and datapath.
// Depends on pbhs_pkg, pbhs_ctrl and pbhs_dp.
//
// Input items (command, index, write_value, now) enter on in_valid/in_stall.
// Result items leave on out_valid/out_stall; a read of an element with n history
// values gives n items, oldest first, with last set on the final one; every
// other item gives one result.
// One item is worked on at a time. An accepted item is registered and range
// checked, and an out of range item gives its result. Otherwise the slot buffer
// is looked up and the element metadata read; a write or a read without history
// then gives its result. A read with history reads its latest value, then its
// oldest entry and gives it, and each further entry once the previous is taken.
// After reset the element metadata memory is cleared, one entry a cycle, which
// keeps in_stall high until all 8192 entries are cleared; array_size returns to
// 8192 and slot i holds page i. While out_stall is high the result holds and no
// new item is taken. array_size is written over the APB port at address 0.
`default_nettype none
module page_buffer_history_store_top
  import pbhs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     command,
  input  wire logic [IDX_W-1:0]         index,
  input  wire logic signed [DATA_W-1:0] write_value,
  input  wire logic [DATA_W-1:0]        now,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          status,
  output logic                          hit,
  output logic [SLOT_W-1:0]             slot,
  output logic                          wrote_back,
  output logic [PAGE_W-1:0]             victim_page,
  output logic signed [DATA_W-1:0]      latest_value,
  output logic                          modified_flag,
  output logic signed [DATA_W-1:0]      history_entry,
  output logic [POS_W-1:0]              history_pos,
  output logic                          last
);

  logic [IDX_W-1:0] array_size;
  ctrl_cmd_t        cmd;
  dp_status_t       st;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ARRAY_SIZE) ? 32'(array_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      array_size <= RESET_SIZE;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ARRAY_SIZE) begin
      array_size <= pwdata[IDX_W-1:0];
    end
  end

  pbhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pbhs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .array_size    (array_size),
    .command       (command),
    .index         (index),
    .write_value   (write_value),
    .now           (now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .hit           (hit),
    .slot          (slot),
    .wrote_back    (wrote_back),
    .victim_page   (victim_page),
    .latest_value  (latest_value),
    .modified_flag (modified_flag),
    .history_entry (history_entry),
    .history_pos   (history_pos),
    .last          (last)
  );

endmodule
`default_nettype wire

@@ dv/page_buffer_history_store_top_tb.sv @@
// Testbench for the page buffer history store top level.
// Drives items with random gaps and stalls and checks every result against a
// built-in prediction of slots, write back and element histories; uses pbhs_pkg.
`timescale 1ns / 100ps
`default_nettype none
module page_buffer_history_store_top_tb;
  import pbhs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic                     status;
    logic                     hit;
    logic [SLOT_W-1:0]        slot;
    logic                     wrote_back;
    logic [PAGE_W-1:0]        victim_page;
    logic signed [DATA_W-1:0] latest_value;
    logic                     modified_flag;
    logic signed [DATA_W-1:0] history_entry;
    logic [POS_W-1:0]         history_pos;
    logic                     last;
  } access_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_READ;
  logic [IDX_W-1:0] index = '0;
  logic signed [DATA_W-1:0] write_value = '0;
  logic [DATA_W-1:0] now = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status, hit, wrote_back, modified_flag, last;
  logic [SLOT_W-1:0] slot;
  logic [PAGE_W-1:0] victim_page;
  logic signed [DATA_W-1:0] latest_value, history_entry;
  logic [POS_W-1:0] history_pos;

  page_buffer_history_store_top u_top (.*);

  always #10 clk = ~clk;

  // Predicted block state.
  logic [IDX_W-1:0]  cur_size;
  logic [PAGE_W-1:0] buf_page [BUFFER_SLOTS];
  logic              buf_valid [BUFFER_SLOTS];
  logic              buf_dirty [BUFFER_SLOTS];
  logic [DATA_W-1:0] buf_time [BUFFER_SLOTS];
  logic [DATA_W-1:0] elem_hist [TOTAL_ELEMS][HISTORY_DEPTH];
  int unsigned       elem_cnt [TOTAL_ELEMS];
  logic              elem_written [TOTAL_ELEMS];

  access_result_t pending_results[$];
  int errors = 0;
  int unsigned cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic [DATA_W-1:0] clock_now = '0;

  task automatic predict_access(input logic cmd, input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] wv, input logic [DATA_W-1:0] nw);
    access_result_t r;
    int s;
    int pg;
    int c;
    logic h;
    logic wb;
    logic [PAGE_W-1:0] vic;
    r = '0;
    s = -1;
    h = 1'b0;
    wb = 1'b0;
    vic = '0;
    if (idx >= cur_size || idx >= TOTAL_ELEMS) begin
      r.status = 1'b1;
      r.last = 1'b1;
      pending_results.push_back(r);
      return;
    end
    pg = idx / PAGE_ELEMENTS;
    for (int i = 0; i < BUFFER_SLOTS; i++) begin
      if (s < 0 && buf_valid[i] && buf_page[i] == pg) begin
        s = i;
        h = 1'b1;
      end
    end
    if (s < 0) begin
      for (int i = 0; i < BUFFER_SLOTS; i++) if (s < 0 && !buf_valid[i]) s = i;
      if (s < 0) begin
        s = 0;
        for (int i = 1; i < BUFFER_SLOTS; i++) if (buf_time[i] < buf_time[s]) s = i;
        if (buf_dirty[s]) begin
          wb = 1'b1;
          vic = buf_page[s];
        end
      end
      buf_page[s] = PAGE_W'(pg);
      buf_valid[s] = 1'b1;
      buf_dirty[s] = 1'b0;
      buf_time[s] = nw;
    end
    r.hit = h;
    r.slot = SLOT_W'(s);
    r.wrote_back = wb;
    r.victim_page = vic;
    c = elem_cnt[idx];
    if (cmd == CMD_WRITE) begin
      if (c < HISTORY_DEPTH) begin
        elem_hist[idx][c] = wv;
        elem_cnt[idx] = c + 1;
      end else begin
        for (int j = 0; j < HISTORY_DEPTH - 1; j++) elem_hist[idx][j] = elem_hist[idx][j+1];
        elem_hist[idx][HISTORY_DEPTH-1] = wv;
      end
      elem_written[idx] = 1'b1;
      buf_dirty[s] = 1'b1;
      buf_time[s] = nw;
      r.last = 1'b1;
      pending_results.push_back(r);
    end else if (c == 0 || !elem_written[idx]) begin
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      for (int j = 0; j < c; j++) begin
        r.latest_value = elem_hist[idx][c-1];
        r.modified_flag = 1'b1;
        r.history_entry = elem_hist[idx][j];
        r.history_pos = POS_W'(j);
        r.last = (j + 1 == c);
        pending_results.push_back(r);
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] wv, input logic [DATA_W-1:0] nw);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    index <= idx;
    write_value <= wv;
    now <= nw;
    do @(posedge clk); while (in_stall);
    predict_access(cmd, idx, wv, nw);
  endtask

  task automatic drain_results();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_ARRAY_SIZE) cur_size = data[IDX_W-1:0];
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    access_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (hit !== e.hit) begin
          $error("hit exp %0d got %0d", e.hit, hit); errors++;
        end
        if (slot !== e.slot) begin
          $error("slot exp %0d got %0d", e.slot, slot); errors++;
        end
        if (wrote_back !== e.wrote_back) begin
          $error("wrote_back exp %0d got %0d", e.wrote_back, wrote_back); errors++;
        end
        if (victim_page !== e.victim_page) begin
          $error("victim_page exp %0d got %0d", e.victim_page, victim_page); errors++;
        end
        if (latest_value !== e.latest_value) begin
          $error("latest_value exp %0d got %0d", e.latest_value, latest_value); errors++;
        end
        if (modified_flag !== e.modified_flag) begin
          $error("modified_flag exp %0d got %0d", e.modified_flag, modified_flag); errors++;
        end
        if (history_entry !== e.history_entry) begin
          $error("history_entry exp %0d got %0d", e.history_entry, history_entry); errors++;
        end
        if (history_pos !== e.history_pos) begin
          $error("history_pos exp %0d got %0d", e.history_pos, history_pos); errors++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_history_directed();
    send_item(CMD_READ, 0, 0, 32'd0);
    send_item(CMD_WRITE, 0, 32'h7fffffff, 32'd1);
    send_item(CMD_WRITE, 0, 32'h80000000, 32'd2);
    send_item(CMD_READ, 0, 0, 32'd3);
    send_item(CMD_WRITE, 0, 32'h0000_0001, 32'd4);
    send_item(CMD_WRITE, 0, 32'hffff_ffff, 32'd5);
    send_item(CMD_WRITE, 0, 32'h1234_5678, 32'd6);
    send_item(CMD_READ, 0, 0, 32'd7);
    send_item(CMD_WRITE, IDX_W'(TOTAL_ELEMS - 1), 32'h5555_aaaa, 32'hffff_ffff);
    send_item(CMD_READ, IDX_W'(TOTAL_ELEMS - 1), 0, 32'hffff_ffff);
    send_item(CMD_READ, 14'h3fff, 32'hffff_ffff, 32'd8);
    send_item(CMD_WRITE, 14'h3fff, 32'hffff_ffff, 32'd8);
    drain_results();
  endtask

  task automatic test_eviction_directed();
    for (int p = 1; p < 6; p++) begin
      send_item(CMD_WRITE, IDX_W'(p * PAGE_ELEMENTS + p), DATA_W'(p), DATA_W'(100 + p));
    end
    send_item(CMD_READ, IDX_W'(8 * PAGE_ELEMENTS), 0, 32'd0);
    send_item(CMD_READ, IDX_W'(9 * PAGE_ELEMENTS), 0, 32'd200);
    send_item(CMD_READ, IDX_W'(1 * PAGE_ELEMENTS + 1), 0, 32'd201);
    drain_results();
  endtask

  task automatic test_array_size_limits();
    write_register(ADDR_ARRAY_SIZE, 32'd1);
    send_item(CMD_READ, 0, 0, 32'd300);
    send_item(CMD_WRITE, 1, 32'd7, 32'd301);
    drain_results();
    write_register(ADDR_ARRAY_SIZE, 32'd0);
    send_item(CMD_READ, 0, 0, 32'd302);
    drain_results();
    write_register(ADDR_ARRAY_SIZE, 32'h3fff);
    write_register(PADDR_W'(4), 32'd5);
    send_item(CMD_WRITE, IDX_W'(TOTAL_ELEMS), 32'd9, 32'd303);
    send_item(CMD_READ, IDX_W'(TOTAL_ELEMS - 1), 0, 32'd304);
    drain_results();
    write_register(ADDR_ARRAY_SIZE, 32'd8192);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    logic [IDX_W-1:0] idx;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) idx = IDX_W'($urandom);
      else idx = IDX_W'($urandom_range(0, 9) * PAGE_ELEMENTS + $urandom_range(0, 3));
      if ($urandom_range(19) == 0) clock_now = $urandom;
      else clock_now = DATA_W'(clock_now + $urandom_range(0, 3));
      send_item(1'($urandom_range(1)), idx, $urandom, clock_now);
    end
    drain_results();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    cur_size = RESET_SIZE;
    for (int i = 0; i < BUFFER_SLOTS; i++) begin
      buf_page[i] = PAGE_W'(i);
      buf_valid[i] = (i < RESET_PAGES);
      buf_dirty[i] = 1'b0;
      buf_time[i] = '0;
    end
    for (int i = 0; i < TOTAL_ELEMS; i++) begin
      elem_cnt[i] = 0;
      elem_written[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_history_directed();
    test_eviction_directed();
    test_array_size_limits();
    test_random_traffic(0, 0, 65);
    write_register(ADDR_ARRAY_SIZE, 32'd700);
    test_random_traffic(57, 0, 65);
    write_register(ADDR_ARRAY_SIZE, 32'h3fff);
    test_random_traffic(0, 57, 65);
    write_register(ADDR_ARRAY_SIZE, 32'd8192);
    test_random_traffic(27, 27, 65);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
